>>> hdl/wlpm_pkg.sv
package wlpm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF       = 16;

    localparam int VOXEL_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int RGB_W      = 3 * BYTE_W;
    localparam int PROD_W     = 2 * VOXEL_W;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] LOW_LIMIT_RST   = 32'd0;
    localparam logic [31:0] HIGH_LIMIT_RST  = 32'd65536;
    localparam logic [31:0] INDEX_SCALE_RST = 32'd16711680;
    localparam logic [7:0]  TOP_INDEX_RST   = 8'd255;
    localparam logic [7:0]  ALPHA_VALUE_RST = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT   = 3'd0,
        CFG_HIGH_LIMIT  = 3'd1,
        CFG_INDEX_SCALE = 3'd2,
        CFG_TOP_INDEX   = 3'd3,
        CFG_ALPHA_VALUE = 3'd4
    } wlpm_cfg_idx_t;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_WRITE = 1'b1
    } wlpm_op_t;

    typedef struct packed {
        logic signed [VOXEL_W-1:0] low_limit;
        logic signed [VOXEL_W-1:0] high_limit;
        logic [VOXEL_W-1:0]        index_scale;
        logic [BYTE_W-1:0]         top_index;
        logic [BYTE_W-1:0]         alpha_value;
    } wlpm_cfg_t;

    // control that rides along with each word in the pipe
    typedef struct packed {
        logic valid;
        logic write;
        logic last;
        logic at_top;
        logic at_zero;
    } wlpm_ctl_t;

endpackage

>>> hdl/wlpm_window.sv
module wlpm_window (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  wlpm_pkg::wlpm_cfg_t                cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  wlpm_pkg::wlpm_op_t                 in_op,
    input  logic signed [wlpm_pkg::VOXEL_W-1:0] in_voxel,
    input  logic [wlpm_pkg::BYTE_W-1:0]        in_entry_index,
    input  logic [wlpm_pkg::RGB_W-1:0]         in_entry_rgb,
    input  logic                               in_last,
    input  logic                               out_ready,
    output wlpm_pkg::wlpm_ctl_t                out_ctl,
    output logic [wlpm_pkg::PROD_W-1:0]        out_prod,
    output logic [wlpm_pkg::BYTE_W-1:0]        out_entry_index,
    output logic [wlpm_pkg::RGB_W-1:0]         out_entry_rgb
);

    wlpm_pkg::wlpm_ctl_t ctl1_reg, ctl1_next;
    wlpm_pkg::wlpm_ctl_t ctl2_reg;
    logic [wlpm_pkg::VOXEL_W-1:0]  diff_reg, diff_next;
    logic [wlpm_pkg::BYTE_W-1:0]   idx1_reg, idx2_reg;
    logic [wlpm_pkg::RGB_W-1:0]    rgb1_reg, rgb2_reg;
    logic [wlpm_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [wlpm_pkg::VOXEL_W:0] diff_wide;
    logic rdy1, rdy2;

    assign rdy2     = !ctl2_reg.valid || out_ready;
    assign rdy1     = !ctl1_reg.valid || rdy2;
    assign in_ready = rdy1;

    // stage 1: window compares and offset from the low limit
    // inside the window the offset is below 2^32, so 32 bits hold it
    always_comb begin
        diff_wide         = {in_voxel[wlpm_pkg::VOXEL_W-1], in_voxel}
                          - {cfg.low_limit[wlpm_pkg::VOXEL_W-1], cfg.low_limit};
        diff_next         = diff_wide[wlpm_pkg::VOXEL_W-1:0];
        ctl1_next.valid   = in_valid;
        ctl1_next.write   = (in_op == wlpm_pkg::OP_WRITE);
        ctl1_next.last    = in_last;
        ctl1_next.at_top  = (in_voxel >= cfg.high_limit);
        ctl1_next.at_zero = (in_voxel <= cfg.low_limit);
    end

    // stage 2: offset times index scale
    assign prod_next = diff_reg * cfg.index_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            if (rdy1) begin
                ctl1_reg <= ctl1_next;
            end
            if (rdy2) begin
                ctl2_reg <= ctl1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            diff_reg <= diff_next;
            idx1_reg <= in_entry_index;
            rgb1_reg <= in_entry_rgb;
        end
        if (rdy2 && ctl1_reg.valid) begin
            prod_reg <= prod_next;
            idx2_reg <= idx1_reg;
            rgb2_reg <= rgb1_reg;
        end
    end

    assign out_ctl         = ctl2_reg;
    assign out_prod        = prod_reg;
    assign out_entry_index = idx2_reg;
    assign out_entry_rgb   = rgb2_reg;

endmodule

>>> hdl/wlpm_palette.sv
module wlpm_palette #(
    parameter int PALETTE_ENTRIES = wlpm_pkg::PALETTE_ENTRIES_DEF,
    parameter int FRAC_BITS       = wlpm_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wlpm_pkg::wlpm_cfg_t           cfg,
    input  wlpm_pkg::wlpm_ctl_t           in_ctl,
    output logic                          in_ready,
    input  logic [wlpm_pkg::PROD_W-1:0]   in_prod,
    input  logic [wlpm_pkg::BYTE_W-1:0]   in_entry_index,
    input  logic [wlpm_pkg::RGB_W-1:0]    in_entry_rgb,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wlpm_pkg::RGB_W-1:0]    out_rgb,
    output logic                          out_last
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam int SHIFT  = 2 * FRAC_BITS;

    logic [wlpm_pkg::RGB_W-1:0] mem [PALETTE_ENTRIES];

    logic                       valid_reg;
    logic                       last_reg;
    logic [wlpm_pkg::RGB_W-1:0] rd_data_reg;
    logic [wlpm_pkg::PROD_W-1:0] scaled;
    logic [wlpm_pkg::BYTE_W-1:0] index;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic                       wr_en, rd_en, rdy3;

    assign rdy3     = !valid_reg || out_ready;
    assign in_ready = rdy3;

    always_comb begin
        scaled = in_prod >> SHIFT;
        if (in_ctl.at_top) begin
            index = cfg.top_index;
        end else if (in_ctl.at_zero) begin
            index = '0;
        end else if (scaled > wlpm_pkg::PROD_W'(cfg.top_index)) begin
            index = cfg.top_index;
        end else begin
            index = scaled[wlpm_pkg::BYTE_W-1:0];
        end
        if (32'(index) > PALETTE_ENTRIES - 1) begin
            rd_addr = ADDR_W'(PALETTE_ENTRIES - 1);
        end else begin
            rd_addr = ADDR_W'(index);
        end
        wr_addr = ADDR_W'(in_entry_index);
    end

    // writes and reads are taken in stream order at this one port, so a
    // read always sees every earlier write
    assign wr_en = rdy3 && in_ctl.valid && in_ctl.write
                   && (32'(in_entry_index) < PALETTE_ENTRIES);
    assign rd_en = rdy3 && in_ctl.valid && !in_ctl.write;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_entry_rgb;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            last_reg    <= in_ctl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rdy3) begin
            valid_reg <= in_ctl.valid && !in_ctl.write;
        end
    end

    assign out_valid = valid_reg;
    assign out_rgb   = rd_data_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/window_level_palette_mapper.sv
// channel | dir | tdata (low bit up)                          | tuser  | tlast
// s_      | in  | voxel, entry_index, entry_red/green/blue    | opcode | last_voxel
// m_      | out | red, green, blue, alpha                      | -      | last_pixel
// cfg_    | in  | write enable, index 0..4, data               | -      | -
//
// One word per clock unless m_ stalls, through a three-register pipe:
// input compare/offset, 32x32 multiply, index clamp with palette read; the read
// register drives m_, and an accepted word passes all three in turn to m_tvalid.
// Palette writes go in stream order at the same memory port; they give no output.
// Reset is synchronous; the palette holds no reset value.
// A stall on m_ fills bubbles first; s_tready drops only when all stages are full.
module window_level_palette_mapper #(
    parameter int PALETTE_ENTRIES = wlpm_pkg::PALETTE_ENTRIES_DEF,
    parameter int FRAC_BITS       = wlpm_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [wlpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wlpm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // voxel[31:0], entry_index[39:32], entry_red[47:40],
    // entry_green[55:48], entry_blue[63:56]
    input  logic [wlpm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                         s_tuser,   // opcode
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [wlpm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    wlpm_pkg::wlpm_cfg_t cfg_reg;
    wlpm_pkg::wlpm_ctl_t ctl2;
    logic [wlpm_pkg::PROD_W-1:0] prod2;
    logic [wlpm_pkg::BYTE_W-1:0] idx2;
    logic [wlpm_pkg::RGB_W-1:0]  rgb2, pix_rgb;
    logic rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_limit   <= wlpm_pkg::LOW_LIMIT_RST;
            cfg_reg.high_limit  <= wlpm_pkg::HIGH_LIMIT_RST;
            cfg_reg.index_scale <= wlpm_pkg::INDEX_SCALE_RST;
            cfg_reg.top_index   <= wlpm_pkg::TOP_INDEX_RST;
            cfg_reg.alpha_value <= wlpm_pkg::ALPHA_VALUE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                wlpm_pkg::CFG_LOW_LIMIT: begin
                    cfg_reg.low_limit <= cfg_wdata;
                end
                wlpm_pkg::CFG_HIGH_LIMIT: begin
                    cfg_reg.high_limit <= cfg_wdata;
                end
                wlpm_pkg::CFG_INDEX_SCALE: begin
                    cfg_reg.index_scale <= cfg_wdata;
                end
                wlpm_pkg::CFG_TOP_INDEX: begin
                    cfg_reg.top_index <= cfg_wdata[wlpm_pkg::BYTE_W-1:0];
                end
                wlpm_pkg::CFG_ALPHA_VALUE: begin
                    cfg_reg.alpha_value <= cfg_wdata[wlpm_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wlpm_window u_window (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_op           (wlpm_pkg::wlpm_op_t'(s_tuser[0])),
        .in_voxel        (s_tdata[31:0]),
        .in_entry_index  (s_tdata[39:32]),
        .in_entry_rgb    ({s_tdata[63:56], s_tdata[55:48], s_tdata[47:40]}),
        .in_last         (s_tlast),
        .out_ready       (rdy3),
        .out_ctl         (ctl2),
        .out_prod        (prod2),
        .out_entry_index (idx2),
        .out_entry_rgb   (rgb2)
    );

    wlpm_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .FRAC_BITS       (FRAC_BITS)
    ) u_palette (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_ctl         (ctl2),
        .in_ready       (rdy3),
        .in_prod        (prod2),
        .in_entry_index (idx2),
        .in_entry_rgb   (rgb2),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_rgb        (pix_rgb),
        .out_last       (m_tlast)
    );

    // the user changes config only while idle (not enforced); alpha reads cfg_reg
    assign m_tdata = {cfg_reg.alpha_value, pix_rgb};

endmodule

>>> hdl/wlpm_checker.sv
module wlpm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wlpm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // output word held while stalled
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_ word changed while stalled");

    // a free output stage frees the whole pipe back to the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind window_level_palette_mapper wlpm_checker u_wlpm_checker (.*);
